// File: src/tccs_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor/scroll package
// Shared types, field widths and character constants for the console engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

    // default screen geometry
    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    // fixed payload field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CMD_W  = 2;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PRINT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    // character and attribute constants
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;

    // configuration register indexes
    localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  cell_col;
        logic [ROW_W-1:0]  cell_row;
        logic [ATTR_W-1:0] cell_attr_in;
    } req_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
    } res_item_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic init_wr;
        logic capture;
        logic exec;
        logic fill_wr;
        logic sweep_wrap;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic init_last;
        logic fill_last;
        logic need_scroll;
        logic out_free;
    } ctrl_status_t;

endpackage

// File: src/text_console_cursor_scroll_unit.sv
// ----------------------------------------------------------------------------
// Text console cursor/scroll unit
// Character-cell console engine with print, read cell and write cell requests.
// ----------------------------------------------------------------------------
// One request at a time: a print, read or write request is captured, executed
// and its result loaded before the next acceptance, and a print that moves the
// cursor below the last row adds a fill pass, one cycle per cell while the
// bottom row is filled with spaces through the single write port of the screen
// memory (the rows themselves rotate through a top-row pointer rather than
// being copied). After reset the screen memory is swept to spaces with
// attribute 0x07, one cell a cycle, and no request is taken until it ends; the
// text_color register at APB offset 0 is meant to be written only while no
// request is in flight. A finished result waits in an output register while
// the next request is accepted.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit
#(
    parameter int COLS = tccs_pkg::DEF_COLS,
    parameter int ROWS = tccs_pkg::DEF_ROWS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tccs_pkg::req_item_t req_item,
    output logic                res_valid,
    input  logic                res_ready,
    output tccs_pkg::res_item_t res_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [tccs_pkg::ATTR_W-1:0] text_color_reg;
    logic [0:0]                  reg_index;
    logic                        cfg_write;

    tccs_pkg::ctrl_cmd_t    ctrl;
    tccs_pkg::ctrl_status_t status;

    // one register, so every word address decodes to it
    assign reg_index = paddr[1:1] & 1'b0;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tccs_pkg::DEFAULT_ATTR;
        end
        else if (cfg_write && (reg_index == tccs_pkg::REG_TEXT_COLOR))
        begin
            text_color_reg <= pwdata[tccs_pkg::ATTR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            tccs_pkg::REG_TEXT_COLOR: prdata = 32'(text_color_reg);
            default:                  prdata = '0;
        endcase
    end

    tccs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    tccs_datapath
    #(
        .COLS (COLS),
        .ROWS (ROWS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .text_color (text_color_reg),
        .req_item   (req_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

endmodule

// File: src/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// Text console controller
// Sequences the clearing pass, command execution, scroll fill and result load.
// ----------------------------------------------------------------------------
module tccs_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  tccs_pkg::ctrl_status_t status,
    output tccs_pkg::ctrl_cmd_t    ctrl
);

    tccs_pkg::state_t state_reg;
    tccs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tccs_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tccs_pkg::ST_INIT:
            begin
                if (status.init_last)
                begin
                    state_next = tccs_pkg::ST_IDLE;
                end
            end
            tccs_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = tccs_pkg::ST_EXEC;
                end
            end
            tccs_pkg::ST_EXEC:
            begin
                if (status.need_scroll)
                begin
                    state_next = tccs_pkg::ST_SCROLL;
                end
                else
                begin
                    state_next = tccs_pkg::ST_RESULT;
                end
            end
            tccs_pkg::ST_SCROLL:
            begin
                if (status.fill_last)
                begin
                    state_next = tccs_pkg::ST_RESULT;
                end
            end
            tccs_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = tccs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tccs_pkg::ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            tccs_pkg::ST_INIT:
            begin
                ctrl.init_wr    = 1'b1;
                ctrl.sweep_wrap = status.init_last;
            end
            tccs_pkg::ST_IDLE:
            begin
                req_ready    = 1'b1;
                ctrl.capture = req_valid;
            end
            tccs_pkg::ST_EXEC:
            begin
                ctrl.exec = 1'b1;
            end
            tccs_pkg::ST_SCROLL:
            begin
                ctrl.fill_wr    = 1'b1;
                ctrl.sweep_wrap = status.fill_last;
            end
            tccs_pkg::ST_RESULT:
            begin
                ctrl.load_out = status.out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// File: src/tccs_datapath.sv
// ----------------------------------------------------------------------------
// Text console datapath
// Screen store with rotating top row, cursor, request and result registers.
// ----------------------------------------------------------------------------
module tccs_datapath
#(
    parameter int COLS = tccs_pkg::DEF_COLS,
    parameter int ROWS = tccs_pkg::DEF_ROWS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tccs_pkg::ctrl_cmd_t            ctrl,
    output tccs_pkg::ctrl_status_t         status,
    input  logic [tccs_pkg::ATTR_W-1:0]    text_color,
    input  tccs_pkg::req_item_t            req_item,
    output logic                           res_valid,
    input  logic                           res_ready,
    output tccs_pkg::res_item_t            res_item
);

    localparam int DEPTH = ROWS * COLS;
    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(DEPTH);

    localparam logic [AW-1:0] COLS_A     = AW'(COLS);
    localparam logic [RW:0]   ROWS_S     = (RW+1)'(ROWS);
    localparam logic [CW-1:0] COL_LAST   = CW'(COLS - 1);
    localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
    localparam logic [AW-1:0] INIT_LAST  = AW'(DEPTH - 1);
    localparam logic [AW-1:0] FILL_LAST  = AW'(COLS - 1);
    localparam logic [tccs_pkg::COL_W-1:0] COLS_F = tccs_pkg::COL_W'(COLS);
    localparam logic [tccs_pkg::ROW_W-1:0] ROWS_F = tccs_pkg::ROW_W'(ROWS);

    logic [tccs_pkg::CELL_W-1:0] mem [0:DEPTH-1];
    logic [tccs_pkg::CELL_W-1:0] rd_data_reg;

    tccs_pkg::req_item_t req_reg;
    tccs_pkg::res_item_t res_item_reg;
    logic                res_valid_reg;

    logic [CW-1:0] cursor_col_reg;
    logic [CW-1:0] cursor_col_next;
    logic [RW-1:0] cursor_row_reg;
    logic [RW-1:0] cursor_row_next;
    logic [RW-1:0] top_reg;
    logic [RW-1:0] top_next;
    logic [AW-1:0] sweep_cnt_reg;

    logic is_print;
    logic is_read;
    logic is_write;
    logic is_newline;
    logic in_range;
    logic col_last;
    logic row_last;
    logic line_feed;

    logic [RW:0]   cur_sum;
    logic [RW:0]   req_sum;
    logic [RW-1:0] cur_phys;
    logic [RW-1:0] req_phys;
    logic [AW-1:0] cur_base;
    logic [AW-1:0] req_base;
    logic [AW-1:0] rd_addr;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [tccs_pkg::CELL_W-1:0] mem_wdata;

    // request decode
    assign is_print   = (req_reg.cmd == tccs_pkg::CMD_PRINT);
    assign is_read    = (req_reg.cmd == tccs_pkg::CMD_READ);
    assign is_write   = (req_reg.cmd == tccs_pkg::CMD_WRITE);
    assign is_newline = (req_reg.char_code == tccs_pkg::NEWLINE_CODE);
    assign in_range   = (req_reg.cell_col < COLS_F) && (req_reg.cell_row < ROWS_F);
    assign col_last   = (cursor_col_reg == COL_LAST);
    assign row_last   = (cursor_row_reg == ROW_LAST);
    assign line_feed  = is_newline || col_last;

    // logical row to physical row: the screen rotates instead of copying
    always_comb
    begin
        cur_sum = {1'b0, cursor_row_reg} + {1'b0, top_reg};
        req_sum = {1'b0, req_reg.cell_row[RW-1:0]} + {1'b0, top_reg};
        if (cur_sum >= ROWS_S)
        begin
            cur_sum = cur_sum - ROWS_S;
        end
        if (req_sum >= ROWS_S)
        begin
            req_sum = req_sum - ROWS_S;
        end
        cur_phys = cur_sum[RW-1:0];
        req_phys = req_sum[RW-1:0];
        cur_base = AW'(cur_phys) * COLS_A;
        req_base = AW'(req_phys) * COLS_A;
    end

    assign rd_addr = in_range ? (req_base + AW'(req_reg.cell_col[CW-1:0])) : '0;

    // write port select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = {tccs_pkg::DEFAULT_ATTR, tccs_pkg::SPACE_CODE};
        if (ctrl.init_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
        end
        else if (ctrl.fill_wr)
        begin
            // cursor sits on the bottom row during a scroll
            mem_we    = 1'b1;
            mem_waddr = cur_base + AW'(sweep_cnt_reg[CW-1:0]);
            mem_wdata = {text_color, tccs_pkg::SPACE_CODE};
        end
        else if (ctrl.exec && is_print && !is_newline)
        begin
            mem_we    = 1'b1;
            mem_waddr = cur_base + AW'(cursor_col_reg);
            mem_wdata = {text_color, req_reg.char_code};
        end
        else if (ctrl.exec && is_write && in_range)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr;
            mem_wdata = {req_reg.cell_attr_in, req_reg.char_code};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // cursor advance
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        top_next        = top_reg;
        if (ctrl.exec && is_print)
        begin
            if (line_feed)
            begin
                cursor_col_next = '0;
                if (row_last)
                begin
                    top_next = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;
                end
                else
                begin
                    cursor_row_next = cursor_row_reg + 1'b1;
                end
            end
            else
            begin
                cursor_col_next = cursor_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            top_reg        <= '0;
            sweep_cnt_reg  <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            top_reg        <= top_next;
            if (ctrl.init_wr || ctrl.fill_wr)
            begin
                sweep_cnt_reg <= ctrl.sweep_wrap ? '0 : sweep_cnt_reg + 1'b1;
            end
            if (ctrl.load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            req_reg <= req_item;
        end
        if (ctrl.load_out)
        begin
            res_item_reg.cursor_col <= tccs_pkg::COL_W'(cursor_col_reg);
            res_item_reg.cursor_row <= tccs_pkg::ROW_W'(cursor_row_reg);
            if (is_read && in_range)
            begin
                res_item_reg.cell_char <= rd_data_reg[tccs_pkg::CHAR_W-1:0];
                res_item_reg.cell_attr <= rd_data_reg[tccs_pkg::CELL_W-1:tccs_pkg::CHAR_W];
            end
            else
            begin
                res_item_reg.cell_char <= '0;
                res_item_reg.cell_attr <= '0;
            end
        end
    end

    assign status.init_last   = (sweep_cnt_reg == INIT_LAST);
    assign status.fill_last   = (sweep_cnt_reg == FILL_LAST);
    assign status.need_scroll = is_print && line_feed && row_last;
    assign status.out_free    = !res_valid_reg || res_ready;

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Text console cursor/scroll unit testbench
// Directed table of print, read and write requests, then four random phases
// with different idle and stall mixes and text colors. Typed rows are checked
// against the table, all else against a behavioral model of screen and cursor.
// ----------------------------------------------------------------------------
module tb;

    localparam int COLS        = tccs_pkg::DEF_COLS;
    localparam int ROWS        = tccs_pkg::DEF_ROWS;
    localparam int RAND_PER_PH = 308;
    localparam int SETTLE      = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_GAP     = 40;

    localparam int CMD_W  = tccs_pkg::CMD_W;
    localparam int CHAR_W = tccs_pkg::CHAR_W;
    localparam int ATTR_W = tccs_pkg::ATTR_W;
    localparam int COL_W  = tccs_pkg::COL_W;
    localparam int ROW_W  = tccs_pkg::ROW_W;
    localparam int CELL_W = tccs_pkg::CELL_W;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0]       COLOR_ADDR = 2'(4 * int'(tccs_pkg::REG_TEXT_COLOR));

    typedef struct {
        tccs_pkg::req_item_t req;
        bit                  typed;
        tccs_pkg::res_item_t res;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    tccs_pkg::req_item_t req_item = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    tccs_pkg::res_item_t res_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [1:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // model state
    logic [CELL_W-1:0] screen [COLS*ROWS];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] text_color;

    tccs_pkg::res_item_t pending_results [$];
    dir_row_t            directed_rows [$];
    tccs_pkg::res_item_t oldest_result;

    int idle_pct = 0;
    int stall_pct = 0;
    int line_left = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int print_count = 0;
    int scroll_count = 0;

    text_console_cursor_scroll_unit #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #4 clk = ~clk;

    function automatic void clear_screen_model();
        foreach (screen[i])
            screen[i] = {tccs_pkg::DEFAULT_ATTR, tccs_pkg::SPACE_CODE};
        cur_col = 0;
        cur_row = 0;
        text_color = tccs_pkg::DEFAULT_ATTR;
    endfunction

    function automatic void advance_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            cur_row = ROWS - 1;
            scroll_count++;
            for (int i = 0; i < (ROWS - 1) * COLS; i++)
                screen[i] = screen[i + COLS];
            for (int i = 0; i < COLS; i++)
                screen[(ROWS - 1) * COLS + i] = {text_color, tccs_pkg::SPACE_CODE};
        end
    endfunction

    function automatic tccs_pkg::res_item_t apply_console_request(
        input tccs_pkg::req_item_t rq);
        tccs_pkg::res_item_t rs;
        logic [CELL_W-1:0]   cell_word;
        bit                  in_range;
        int                  idx;
        rs = '0;
        in_range = int'(rq.cell_col) < COLS && int'(rq.cell_row) < ROWS;
        idx = int'(rq.cell_row) * COLS + int'(rq.cell_col);
        case (rq.cmd)
            tccs_pkg::CMD_PRINT:
            begin
                print_count++;
                if (rq.char_code == tccs_pkg::NEWLINE_CODE)
                    advance_line();
                else
                begin
                    screen[cur_row * COLS + cur_col] = {text_color, rq.char_code};
                    cur_col++;
                    if (cur_col >= COLS)
                        advance_line();
                end
            end
            tccs_pkg::CMD_READ:
            begin
                if (in_range)
                begin
                    cell_word = screen[idx];
                    rs.cell_char = cell_word[CHAR_W-1:0];
                    rs.cell_attr = cell_word[CELL_W-1:CHAR_W];
                end
            end
            tccs_pkg::CMD_WRITE:
            begin
                if (in_range)
                    screen[idx] = {rq.cell_attr_in, rq.char_code};
            end
            default:
            begin
            end
        endcase
        rs.cursor_col = COL_W'(cur_col);
        rs.cursor_row = ROW_W'(cur_row);
        return rs;
    endfunction

    // mostly text lines of random length so both wrap and scroll get hit
    function automatic tccs_pkg::req_item_t random_request();
        tccs_pkg::req_item_t rq;
        int                  pick;
        pick = $urandom_range(99);
        rq.cmd          = tccs_pkg::CMD_PRINT;
        rq.char_code    = CHAR_W'($urandom());
        rq.cell_col     = COL_W'($urandom_range(COLS - 1));
        rq.cell_row     = ROW_W'($urandom_range(ROWS - 1));
        rq.cell_attr_in = ATTR_W'($urandom());
        if (pick < 55)
        begin
            if (line_left == 0)
            begin
                rq.char_code = tccs_pkg::NEWLINE_CODE;
                line_left = $urandom_range(120);
            end
            else
                line_left--;
        end
        else if (pick < 72)
            rq.cmd = tccs_pkg::CMD_READ;
        else if (pick < 89)
            rq.cmd = tccs_pkg::CMD_WRITE;
        else if (pick < 94)
            rq.cmd = CMD_UNUSED;
        else
        begin
            rq.cmd      = ($urandom_range(1) == 0) ? tccs_pkg::CMD_READ : tccs_pkg::CMD_WRITE;
            rq.cell_col = COL_W'($urandom());
            rq.cell_row = ROW_W'($urandom());
        end
        return rq;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] cmd, input int ch, input int col,
                                    input int row, input int attr, input bit typed,
                                    input int ecol, input int erow, input int echar,
                                    input int eattr);
        dir_row_t d;
        d.req.cmd          = cmd;
        d.req.char_code    = CHAR_W'(ch);
        d.req.cell_col     = COL_W'(col);
        d.req.cell_row     = ROW_W'(row);
        d.req.cell_attr_in = ATTR_W'(attr);
        d.typed            = typed;
        d.res.cursor_col   = COL_W'(ecol);
        d.res.cursor_row   = ROW_W'(erow);
        d.res.cell_char    = CHAR_W'(echar);
        d.res.cell_attr    = ATTR_W'(eattr);
        directed_rows.push_back(d);
    endfunction

    task automatic send_request(input tccs_pkg::req_item_t rq, input bit typed,
                                input tccs_pkg::res_item_t typed_res);
        int                  gap;
        tccs_pkg::res_item_t predicted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= rq;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = apply_console_request(rq);
        pending_results.push_back(typed ? typed_res : predicted);
        requests_sent++;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= COLOR_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_text_color(input logic [ATTR_W-1:0] color);
        logic [31:0] rd;
        apb_access(1'b1, {24'($urandom()), color}, rd);
        text_color = color;
        apb_access(1'b0, '0, rd);
        if (rd[ATTR_W-1:0] !== color)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("text_color readback: want %02h got %02h", color, rd[ATTR_W-1:0]);
        end
    endtask

    task automatic check_result(input tccs_pkg::res_item_t want,
                                input tccs_pkg::res_item_t got);
        bit bad;
        bad = (got.cursor_col !== want.cursor_col) || (got.cursor_row !== want.cursor_row)
            || (got.cell_char !== want.cell_char) || (got.cell_attr !== want.cell_attr);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"result %0d: want col %0d row %0d char %02h attr %02h,",
                          " got col %0d row %0d char %02h attr %02h"},
                         results_seen, want.cursor_col, want.cursor_row, want.cell_char,
                         want.cell_attr, got.cursor_col, got.cursor_row, got.cell_char,
                         got.cell_attr);
        end
    endtask

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: col %0d row %0d char %02h attr %02h",
                             res_item.cursor_col, res_item.cursor_row, res_item.cell_char,
                             res_item.cell_attr);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_result(oldest_result, res_item);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run exceeded %0d cycles", CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [ATTR_W-1:0] color;
        clear_screen_model();

        // reset screen: spaces with attr 07, cursor at the origin
        add_row(tccs_pkg::CMD_READ,  8'h00, 0,   0,  0,     1, 0, 0, 8'h20, 8'h07);
        add_row(tccs_pkg::CMD_READ,  8'h00, 79,  24, 0,     1, 0, 0, 8'h20, 8'h07);
        // out-of-range reads and the unused command return zero cells
        add_row(tccs_pkg::CMD_READ,  8'h00, 80,  0,  0,     1, 0, 0, 0, 0);
        add_row(tccs_pkg::CMD_READ,  8'hFF, 127, 31, 8'hFF, 1, 0, 0, 0, 0);
        add_row(tccs_pkg::CMD_READ,  8'h00, 0,   25, 0,     1, 0, 0, 0, 0);
        add_row(CMD_UNUSED,          8'hFF, 127, 31, 8'hFF, 1, 0, 0, 0, 0);
        add_row(tccs_pkg::CMD_WRITE, 8'hFF, 0,   0,  8'hFF, 1, 0, 0, 0, 0);
        add_row(tccs_pkg::CMD_READ,  8'h00, 0,   0,  0,     1, 0, 0, 8'hFF, 8'hFF);
        add_row(tccs_pkg::CMD_WRITE, 8'h00, 79,  24, 8'h00, 1, 0, 0, 0, 0);
        add_row(tccs_pkg::CMD_READ,  8'h00, 79,  24, 0,     1, 0, 0, 8'h00, 8'h00);
        // out-of-range writes leave the store alone
        add_row(tccs_pkg::CMD_WRITE, 8'h55, 80,  24, 8'hAA, 1, 0, 0, 0, 0);
        add_row(tccs_pkg::CMD_WRITE, 8'h55, 127, 31, 8'hAA, 1, 0, 0, 0, 0);
        add_row(tccs_pkg::CMD_WRITE, 8'h55, 79,  25, 8'hAA, 1, 0, 0, 0, 0);
        add_row(tccs_pkg::CMD_READ,  8'h00, 79,  24, 0,     1, 0, 0, 8'h00, 8'h00);
        add_row(tccs_pkg::CMD_PRINT, 8'h41, 0,   0,  0,     1, 1, 0, 0, 0);
        add_row(tccs_pkg::CMD_READ,  8'h00, 0,   0,  0,     1, 1, 0, 8'h41, 8'h07);
        add_row(tccs_pkg::CMD_PRINT, 8'h00, 127, 31, 8'hFF, 1, 2, 0, 0, 0);
        add_row(tccs_pkg::CMD_PRINT, 8'hFF, 0,   0,  0,     1, 3, 0, 0, 0);
        // a printed newline moves the cursor and is not stored, a written one is
        add_row(tccs_pkg::CMD_PRINT, tccs_pkg::NEWLINE_CODE, 0, 0, 0, 1, 0, 1, 0, 0);
        add_row(tccs_pkg::CMD_READ,  8'h00, 3,   0,  0,     1, 0, 1, 8'h20, 8'h07);
        add_row(tccs_pkg::CMD_PRINT, tccs_pkg::NEWLINE_CODE, 0, 0, 0, 1, 0, 2, 0, 0);
        add_row(tccs_pkg::CMD_WRITE, tccs_pkg::NEWLINE_CODE, 79, 24, 8'h12, 1, 0, 2, 0, 0);
        add_row(tccs_pkg::CMD_READ,  8'h00, 79,  24, 0,     1, 0, 2, 8'h0A, 8'h12);
        add_row(tccs_pkg::CMD_PRINT, 8'h7A, 0,   0,  0,     0, 0, 0, 0, 0);
        add_row(tccs_pkg::CMD_READ,  8'h00, 0,   2,  0,     0, 0, 0, 0, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  color = 8'h00; end
                1:       begin idle_pct = 56; stall_pct = 0;  color = 8'hFF; end
                2:       begin idle_pct = 0;  stall_pct = 56; color = ATTR_W'($urandom()); end
                default: begin idle_pct = 30; stall_pct = 30; color = ATTR_W'($urandom()); end
            endcase
            set_text_color(color);
            for (int n = 0; n < RAND_PER_PH; n++)
                send_request(random_request(), 1'b0, '0);
        end

        wait_idle();
        if (pending_results.size() != 0)
            mismatches++;

        $display("%0d requests, %0d results: %0d prints, %0d scrolls", requests_sent,
                 results_seen, print_count, scroll_count);
        $display("four random phases across idle/stall mixes, text colors 00, ff and random");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
